>>> rtl/aes_ctr_pkg.sv
// Shared types, constants and AES helper functions for the CTR keystream block.
`default_nettype none
package aes_ctr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundCntW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        last_block;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        out_last;
  } out_word_t;

  // Control from sequencer to round unit.
  typedef struct packed {
    logic load;   // load counter xor key, start key schedule
    logic step;   // run one round
    logic final_round;
  } rnd_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] GfPoly = 8'h1b;

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    gf_double = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  // Byte i of a 128-bit block, byte 0 most significant.
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int unsigned i);
    get_byte = v[127-8*i -: 8];
  endfunction

endpackage
`default_nettype wire

>>> rtl/aes128_ctr_keystream_xor.sv
// Top level: AES-128 CTR keystream XOR with an iterative round unit.
// Sequence: key add (counter XOR key) on the accept edge, then 10 rounds; the final
// XOR with the data word is combinational.
// Steps per word: accept, 10 rounds, result state, back to idle; a new word is taken only once idle.
// The input is stalled while a word is in flight or a result waits.
// Reset (rst, synchronous) clears key, IV and counter to zero and idles.
`default_nettype none
module aes128_ctr_keystream_xor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire aes_ctr_pkg::in_word_t       in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output aes_ctr_pkg::out_word_t           out_data,
  input  wire logic                        cfg_we,
  input  wire logic [aes_ctr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [aes_ctr_pkg::CfgDataW-1:0] cfg_value
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  logic [aes_ctr_pkg::RoundCntW-1:0] round;
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [127:0] ctr;
  aes_ctr_pkg::in_word_t held;
  aes_ctr_pkg::rnd_ctrl_t ctrl;
  logic [127:0] ks;
  logic accept;

  assign accept = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // round unit: load on accept, then ten steps; round 10 skips MixColumns
  assign ctrl.load = accept;
  assign ctrl.step = (state == S_RUN);
  assign ctrl.final_round = (round == aes_ctr_pkg::RoundCntW'(aes_ctr_pkg::NumRounds));

  aes_ctr_round u_round (
    .clk   (clk),
    .ctrl  (ctrl),
    .key   ({key_high, key_low}),
    .ctr   (ctr),
    .state (ks)
  );

  assign out_data.out_high = held.data_high ^ ks[127:64];
  assign out_data.out_low  = held.data_low ^ ks[63:0];
  assign out_data.out_last = held.last_block;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      ctr <= '0;
    end else begin
      if (cfg_we) begin
        unique case (aes_ctr_pkg::cfg_reg_t'(cfg_index))
          aes_ctr_pkg::REG_KEY_HIGH: key_high <= cfg_value;
          aes_ctr_pkg::REG_KEY_LOW:  key_low <= cfg_value;
          aes_ctr_pkg::REG_IV_HIGH: begin
            iv_high <= cfg_value;
            ctr <= {cfg_value, iv_low};
          end
          aes_ctr_pkg::REG_IV_LOW: begin
            iv_low <= cfg_value;
            ctr <= {iv_high, cfg_value};
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            round <= aes_ctr_pkg::RoundCntW'(1);
            held <= in_data;
            // counter advances (or reloads the IV after a last block) now; the round unit already took its copy
            ctr <= in_data.last_block ? {iv_high, iv_low} : ctr + 128'd1;
          end
        end
        S_RUN: begin
          if (ctrl.final_round) begin
            state <= S_OUT;
          end
          round <= round + aes_ctr_pkg::RoundCntW'(1);
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/aes_ctr_round.sv
// One AES round with on-the-fly key expansion, reused for all ten rounds.
`default_nettype none
module aes_ctr_round (
  input  wire logic                  clk,
  input  wire aes_ctr_pkg::rnd_ctrl_t ctrl,
  input  wire logic [127:0]          key,
  input  wire logic [127:0]          ctr,
  output logic      [127:0]          state
);

  logic [127:0] rk;
  logic [7:0]   rcon;
  logic [127:0] rk_next;
  logic [127:0] state_next;

  always_comb begin
    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] a0, a1, a2, a3, t;
    logic [7:0] k [16];
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; t = '0;
    for (int i = 0; i < 16; i++) begin
      k[i] = aes_ctr_pkg::get_byte(rk, i);
    end
    k[0] = k[0] ^ aes_ctr_pkg::SBOX[k[13]] ^ rcon;
    k[1] = k[1] ^ aes_ctr_pkg::SBOX[k[14]];
    k[2] = k[2] ^ aes_ctr_pkg::SBOX[k[15]];
    k[3] = k[3] ^ aes_ctr_pkg::SBOX[k[12]];
    for (int i = 4; i < 16; i++) begin
      k[i] = k[i] ^ k[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      rk_next[127-8*i -: 8] = k[i];
      sb[i] = aes_ctr_pkg::SBOX[aes_ctr_pkg::get_byte(state, i)];
    end
    // ShiftRows
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        sr[4*c+w] = sb[4*((c+w)%4)+w];
      end
    end
    if (!ctrl.final_round) begin
      for (int c = 0; c < 4; c++) begin
        a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
        t = a0 ^ a1 ^ a2 ^ a3;
        sr[4*c]   = a0 ^ t ^ aes_ctr_pkg::gf_double(a0 ^ a1);
        sr[4*c+1] = a1 ^ t ^ aes_ctr_pkg::gf_double(a1 ^ a2);
        sr[4*c+2] = a2 ^ t ^ aes_ctr_pkg::gf_double(a2 ^ a3);
        sr[4*c+3] = a3 ^ t ^ aes_ctr_pkg::gf_double(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_next[127-8*i -: 8] = sr[i] ^ k[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rk <= key;
      rcon <= aes_ctr_pkg::RconInit;
      state <= ctr ^ key;
    end else if (ctrl.step) begin
      rk <= rk_next;
      rcon <= aes_ctr_pkg::gf_double(rcon);
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
